// File: hdl/keyframe_vector_sampler_defines.svh
// assertion macros used by the keyframe sampler checker
`ifndef KEYFRAME_VECTOR_SAMPLER_DEFINES_SVH
`define KEYFRAME_VECTOR_SAMPLER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define KVS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyframe sampler check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define KVS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyframe sampler check failed");

`endif

// File: hdl/kvs_pkg.sv
// shared constants and payload types for the keyframe vector sampler
package kvs_pkg;

  localparam int MAX_KEYS  = 64;
  localparam int KEY_AW    = $clog2(MAX_KEYS);
  localparam int KCNT_W    = 7;
  localparam int FRAC_BITS = 16;
  localparam int T_W       = FRAC_BITS + 1;
  localparam int DCNT_W    = $clog2(FRAC_BITS + 1);
  localparam int VAL_W     = 32;
  localparam int VEC_W     = 3 * VAL_W;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic [KEY_AW-1:0]       key_index;
    logic [VAL_W-1:0]        key_time;
    logic signed [VAL_W-1:0] key_x;
    logic signed [VAL_W-1:0] key_y;
    logic signed [VAL_W-1:0] key_z;
    logic [VAL_W-1:0]        query_time;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] out_x;
    logic signed [VAL_W-1:0] out_y;
    logic signed [VAL_W-1:0] out_z;
    logic [KEY_AW-1:0]       segment;
  } out_t;

endpackage

// File: hdl/kvs_div.sv
// iterative restoring divider for the segment fraction, one quotient bit per cycle
module kvs_div import kvs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [VAL_W-1:0] num,
  input  logic [VAL_W-1:0] den,
  output logic             done,
  output logic [T_W-1:0]   quo
);

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [VAL_W-1:0]  rem;
  logic [VAL_W-1:0]  dvs;
  logic [VAL_W:0]    trial;
  logic [VAL_W:0]    trial_sub;
  logic              ge;

  // first step tests the integer bit, later steps shift the remainder
  always_comb begin
    trial     = (cnt == '0) ? {1'b0, rem} : {rem, 1'b0};
    trial_sub = trial - {1'b0, dvs};
    ge        = (trial >= {1'b0, dvs});
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= num;
        dvs  <= den;
        quo  <= '0;
      end else if (busy) begin
        rem <= ge ? trial_sub[VAL_W-1:0] : trial[VAL_W-1:0];
        quo <= {quo[T_W-2:0], ge};
        if (cnt == DCNT_W'(FRAC_BITS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + DCNT_W'(1);
        end
      end
    end
  end

endmodule

// File: hdl/keyframe_vector_sampler.sv
// keyframe vector sampler: keyframe table with piecewise linear sampling
//
// in_valid/in_ready carry one in_t per transfer. mode load writes the key
// time and x/y/z vector into slot key_index and gives no result. mode query
// samples the curve at query_time and gives one out_t
// on out_valid/out_ready with the vector and the lower key of the segment.
// cfg_we/cfg_data set key_count (clamped to 1..64); write it only when idle, the block does not enforce this.
// A query first reads key 0; with two or more keys and a query past key 0
// it scans the time table one key per cycle, then runs the bit-serial
// divider for the fraction when the segment has length. The search through
// the time table memory and the divider set the latency; one item is in
// work at a time.
// The result sits in an output register; the next item is taken while it
// waits. If the receiver stalls, a finished query holds until the register
// frees. Reset clears key_count to 1 and empties the output; the table
// contents are undefined until loaded.
module keyframe_vector_sampler import kvs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [KCNT_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_FIRST, S_SCAN, S_DIV, S_VLO, S_VHI, S_VCAP, S_MUL, S_ADD, S_DONE
  } state_t;

  state_t state;

  logic [KCNT_W-1:0]       key_count;
  logic [KCNT_W-1:0]       nkeys;
  logic [KCNT_W-1:0]       n_clamped;
  logic [VAL_W-1:0]        qt;
  logic [KEY_AW-1:0]       idx;
  logic [VAL_W-1:0]        prev;
  logic [KEY_AW-1:0]       lo;
  logic [KEY_AW-1:0]       hi;
  logic [T_W-1:0]          tfrac;
  logic [1:0]              comp;
  logic signed [VAL_W-1:0] a_vec [3];
  logic signed [VAL_W-1:0] b_vec [3];
  logic signed [VAL_W-1:0] res   [3];
  logic signed [VAL_W+T_W+1:0] prod;

  // table memories
  logic [VAL_W-1:0]  time_mem [MAX_KEYS];
  logic [VEC_W-1:0]  vec_mem  [MAX_KEYS];
  logic [VAL_W-1:0]  time_q;
  logic [VEC_W-1:0]  vec_q;
  logic [KEY_AW-1:0] t_raddr;
  logic [KEY_AW-1:0] v_raddr;
  logic              load_xfer;
  logic              query_xfer;

  // search and divider hookup
  logic              found;
  logic              last_seg;
  logic              first_hit;
  logic              div_start;
  logic              div_done;
  logic [T_W-1:0]    div_quo;
  logic [VAL_W:0]    diff_ab;
  logic signed [VAL_W-1:0] q_part;

  assign in_ready   = (state == S_IDLE);
  assign load_xfer  = in_valid && in_ready && (in_data.mode == MODE_LOAD);
  assign query_xfer = in_valid && in_ready && (in_data.mode == MODE_QUERY);

  // key count clamp to the table size
  always_comb begin
    if (key_count == '0) begin
      n_clamped = KCNT_W'(1);
    end else if (key_count > KCNT_W'(MAX_KEYS)) begin
      n_clamped = KCNT_W'(MAX_KEYS);
    end else begin
      n_clamped = key_count;
    end
  end

  // read addresses follow the sequencer
  always_comb begin
    case (state)
      S_FIRST: t_raddr = KEY_AW'(1);
      S_SCAN:  t_raddr = idx + KEY_AW'(2);
      default: t_raddr = '0;
    endcase
    case (state)
      S_VHI:   v_raddr = hi;
      default: v_raddr = lo;
    endcase
  end

  // time table, written by loads, read every cycle
  always_ff @(posedge clk) begin
    if (load_xfer) begin
      time_mem[in_data.key_index] <= in_data.key_time;
    end
    time_q <= time_mem[t_raddr];
  end

  // vector table, x in the top word
  always_ff @(posedge clk) begin
    if (load_xfer) begin
      vec_mem[in_data.key_index] <= {in_data.key_x, in_data.key_y, in_data.key_z};
    end
    vec_q <= vec_mem[v_raddr];
  end

  // segment tests
  assign first_hit = (nkeys == KCNT_W'(1)) || (qt <= time_q);
  assign found     = (prev <= qt) && (qt <= time_q);
  assign last_seg  = ({1'b0, idx} + KCNT_W'(2)) >= nkeys;
  assign div_start = (state == S_SCAN) && found && (time_q != prev);

  kvs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (qt - prev),
    .den   (time_q - prev),
    .done  (div_done),
    .quo   (div_quo)
  );

  // exact difference and floor of the scaled product
  assign diff_ab = {b_vec[comp][VAL_W-1], b_vec[comp]} - {a_vec[comp][VAL_W-1], a_vec[comp]};
  assign q_part  = VAL_W'(prod >>> FRAC_BITS);

  // sequencer, key count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      key_count <= KCNT_W'(1);
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        key_count <= cfg_data;
      end
      // output register: take a finished result or retire a transferred one
      if ((state == S_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (query_xfer) begin
            qt    <= in_data.query_time;
            nkeys <= n_clamped;
            idx   <= '0;
            state <= S_FIRST;
          end
        end
        S_FIRST: begin
          prev <= time_q;
          if (first_hit) begin
            lo    <= '0;
            hi    <= '0;
            tfrac <= '0;
            state <= S_VLO;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (found) begin
            lo    <= idx;
            hi    <= idx + KEY_AW'(1);
            tfrac <= '0;
            state <= (time_q != prev) ? S_DIV : S_VLO;
          end else if (last_seg) begin
            lo    <= KEY_AW'(nkeys - KCNT_W'(1));
            hi    <= KEY_AW'(nkeys - KCNT_W'(1));
            tfrac <= '0;
            state <= S_VLO;
          end else begin
            prev <= time_q;
            idx  <= idx + KEY_AW'(1);
          end
        end
        S_DIV: begin
          if (div_done) begin
            tfrac <= div_quo;
            state <= S_VLO;
          end
        end
        S_VLO: begin
          state <= S_VHI;
        end
        S_VHI: begin
          a_vec[0] <= vec_q[3*VAL_W-1:2*VAL_W];
          a_vec[1] <= vec_q[2*VAL_W-1:VAL_W];
          a_vec[2] <= vec_q[VAL_W-1:0];
          state    <= S_VCAP;
        end
        S_VCAP: begin
          b_vec[0] <= vec_q[3*VAL_W-1:2*VAL_W];
          b_vec[1] <= vec_q[2*VAL_W-1:VAL_W];
          b_vec[2] <= vec_q[VAL_W-1:0];
          comp     <= '0;
          state    <= S_MUL;
        end
        S_MUL: begin
          prod  <= (VAL_W+T_W+2)'($signed(diff_ab)) * $signed((VAL_W+T_W+2)'({1'b0, tfrac}));
          state <= S_ADD;
        end
        S_ADD: begin
          res[comp] <= a_vec[comp] + q_part;
          if (comp == 2'd2) begin
            state <= S_DONE;
          end else begin
            comp  <= comp + 2'd1;
            state <= S_MUL;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data.out_x   <= res[0];
            out_data.out_y   <= res[1];
            out_data.out_z   <= res[2];
            out_data.segment <= lo;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/kvs_chk.sv
// port-level checker for the keyframe vector sampler, with its bind
`include "keyframe_vector_sampler_defines.svh"

module kvs_chk import kvs_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              cfg_we,
  input logic [KCNT_W-1:0] cfg_data,
  input logic              in_valid,
  input logic              in_ready,
  input in_t               in_data,
  input logic              out_valid,
  input logic              out_ready,
  input out_t              out_data
);

  logic load_xfer;
  logic query_xfer;

  // transfers seen on the input channel
  assign load_xfer  = in_valid && in_ready && (in_data.mode == MODE_LOAD);
  assign query_xfer = in_valid && in_ready && (in_data.mode == MODE_QUERY);

  // a stalled result stays offered
  `KVS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // a load transfer never creates a result
  `KVS_ASSERT_NEXT(a_load_silent, load_xfer && !out_valid, !out_valid)

  // a query transfer closes the input until its result is built
  `KVS_ASSERT_NEXT(a_query_busy, query_xfer, !in_ready)

  // a new result only appears at the end of query work
  `KVS_ASSERT_NOW(a_out_from_query, $rose(out_valid), !$past(in_ready))

endmodule

bind keyframe_vector_sampler kvs_chk u_kvs_chk (.*);
